// ----- rtl/scx_pkg.sv -----
`default_nettype none

package scx_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MAX_LINE_WIDTH_DEF  = 1024;
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Field widths
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int FW_W    = 11;
  localparam int FH_W    = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd768;
  localparam int ROW_LIMIT = 4096;

  // Input item kinds
  localparam logic OP_PIXEL   = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  // Stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 152;

  localparam int QUEUE_DEPTH = 4;

  // One request between front and back: a palette write or a 2x2 block
  typedef struct packed {
    logic               is_wr;
    logic [IDX_W-1:0]   slot;
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [IDX_W-1:0]   idx_tl;
    logic [IDX_W-1:0]   idx_tr;
    logic [IDX_W-1:0]   idx_bl;
    logic [IDX_W-1:0]   idx_br;
    logic               last;
    logic               done;
  } scx_job_t;

endpackage

`default_nettype wire

// ----- rtl/scx_palette_ram.sv -----
`default_nettype none

module scx_palette_ram #(
  parameter int ENTRIES = scx_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(ENTRIES)-1:0]          wr_addr,
  input  logic [scx_pkg::COLOR_W-1:0]         wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(ENTRIES)-1:0]          rd_addr_a,
  input  logic [$clog2(ENTRIES)-1:0]          rd_addr_b,
  output logic [scx_pkg::COLOR_W-1:0]         rd_data_a,
  output logic [scx_pkg::COLOR_W-1:0]         rd_data_b
);

  logic [scx_pkg::COLOR_W-1:0] mem [ENTRIES];
  logic [scx_pkg::COLOR_W-1:0] rd_a_r;
  logic [scx_pkg::COLOR_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

// ----- rtl/scx_front.sv -----
`default_nettype none

module scx_front #(
  parameter int MAX_LINE_WIDTH = scx_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [scx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scx_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [scx_pkg::IDX_W-1:0]         in_pixel,
  input  logic [scx_pkg::IDX_W-1:0]         in_slot,
  input  logic [scx_pkg::COLOR_W-1:0]       in_color,
  output logic                              q_push,
  output scx_pkg::scx_job_t                 q_job,
  input  logic                              q_full
);

  localparam int XW = $clog2(MAX_LINE_WIDTH);

  typedef logic [XW-1:0]                col_t;
  typedef logic [scx_pkg::ROW_W-1:0]    row_t;
  typedef logic [scx_pkg::IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic self_blk;
    logic left_blk;
    logic above_blk;
    logic pal_wr;
  } job_set_t;

  function automatic col_t w_last_of(input logic [scx_pkg::FW_W-1:0] fw);
    col_t res;
    if (fw == '0) begin
      res = '0;
    end else if (32'(fw) > MAX_LINE_WIDTH) begin
      res = XW'(MAX_LINE_WIDTH - 1);
    end else begin
      res = XW'(fw - scx_pkg::FW_W'(1));
    end
    return res;
  endfunction

  function automatic row_t h_last_of(input logic [scx_pkg::FH_W-1:0] fh);
    row_t res;
    if (fh == '0) begin
      res = '0;
    end else if (32'(fh) > scx_pkg::ROW_LIMIT) begin
      res = scx_pkg::ROW_W'(scx_pkg::ROW_LIMIT - 1);
    end else begin
      res = scx_pkg::ROW_W'(fh - scx_pkg::FH_W'(1));
    end
    return res;
  endfunction

  // Returns {br, bl, tr, tl}
  function automatic logic [4*scx_pkg::IDX_W-1:0] scale2x(input idx_t p, input idx_t a,
                                                          input idx_t b, input idx_t c,
                                                          input idx_t d);
    idx_t e0;
    idx_t e1;
    idx_t e2;
    idx_t e3;
    e0 = (c == a && c != d && a != b) ? a : p;
    e1 = (a == b && a != c && b != d) ? b : p;
    e2 = (d == c && d != b && c != a) ? c : p;
    e3 = (b == d && b != a && d != c) ? d : p;
    return {e3, e2, e1, e0};
  endfunction

  // Frame position and size
  col_t col_r, col_nxt, w_last_r;
  row_t row_r, row_nxt, h_last_r;
  logic last_row;
  logic last_col;

  // Line buffers: the row above the incoming pixel, and the one above that
  idx_t line_prev_mem [MAX_LINE_WIDTH];
  idx_t line_old_mem  [MAX_LINE_WIDTH];
  idx_t prev_x_r;
  idx_t prev_x1_r;
  idx_t old_x_r;
  logic old_wr_pend_r;
  col_t old_wr_addr_r;
  col_t col_inc;

  // Most recent pixels of the current row
  idx_t hist1_r;
  idx_t hist2_r;

  // Classify stage
  logic     s1_valid_r;
  job_set_t s1_pend_r;
  job_set_t sel;
  job_set_t rest;
  logic     s1_done;
  idx_t     s1_px_r;
  idx_t     s1_slot_r;
  logic [scx_pkg::COLOR_W-1:0] s1_color_r;
  col_t     s1_col_r;
  row_t     s1_row_r;
  logic     s1_x_gt0_r;
  logic     s1_x_gt1_r;
  logic     s1_x_last_r;
  logic     s1_r_gt0_r;
  logic     s1_r_gt1_r;
  idx_t     s1_cur1_r;
  idx_t     s1_cur2_r;
  idx_t     s1_diag_r;

  logic in_fire;
  logic pix_fire;

  idx_t nb_p, nb_a, nb_b, nb_c, nb_d;
  col_t blk_col;
  row_t blk_row;
  logic [4*scx_pkg::IDX_W-1:0] picked;

  assign in_fire  = in_valid && in_ready;
  assign pix_fire = in_fire && (in_op == scx_pkg::OP_PIXEL);
  assign last_row = (row_r == h_last_r);
  assign last_col = (col_r == w_last_r);
  assign col_inc  = col_r + 1'b1;

  always_comb begin
    col_nxt = col_inc;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      w_last_r <= w_last_of(scx_pkg::FRAME_WIDTH_RST);
      h_last_r <= h_last_of(scx_pkg::FRAME_HEIGHT_RST);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        scx_pkg::CFG_FRAME_WIDTH: begin
          w_last_r <= w_last_of(cfg_wr_data[scx_pkg::FW_W-1:0]);
          col_r    <= '0;
          row_r    <= '0;
        end
        scx_pkg::CFG_FRAME_HEIGHT: begin
          h_last_r <= h_last_of(cfg_wr_data);
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (pix_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Reads are read-first; the copy into the older line lags one pixel and is
  // forwarded when it lands on the address being read
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      line_prev_mem[col_r] <= in_pixel;
      prev_x_r  <= line_prev_mem[col_r];
      prev_x1_r <= line_prev_mem[col_inc];
      if (old_wr_pend_r) begin
        line_old_mem[old_wr_addr_r] <= prev_x_r;
      end
      if (old_wr_pend_r && old_wr_addr_r == col_r) begin
        old_x_r <= prev_x_r;
      end else begin
        old_x_r <= line_old_mem[col_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_wr_pend_r <= 1'b0;
    end else if (pix_fire) begin
      old_wr_pend_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      old_wr_addr_r <= col_r;
      hist1_r       <= in_pixel;
      hist2_r       <= hist1_r;
    end
  end

  // Pick requests in emission order: palette write, block above, block left, own block
  always_comb begin
    sel = '0;
    if (s1_pend_r.pal_wr) begin
      sel.pal_wr = 1'b1;
    end else if (s1_pend_r.above_blk) begin
      sel.above_blk = 1'b1;
    end else if (s1_pend_r.left_blk) begin
      sel.left_blk = 1'b1;
    end else if (s1_pend_r.self_blk) begin
      sel.self_blk = 1'b1;
    end
    rest = job_set_t'(s1_pend_r & ~sel);
  end

  assign q_push   = s1_valid_r && (s1_pend_r != '0) && !q_full;
  assign s1_done  = s1_valid_r && ((s1_pend_r == '0) || (q_push && rest == '0));
  assign in_ready = !s1_valid_r || s1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      if (in_op == scx_pkg::OP_PALETTE) begin
        s1_pend_r <= '{self_blk: 1'b0, left_blk: 1'b0, above_blk: 1'b0, pal_wr: 1'b1};
      end else begin
        s1_pend_r.pal_wr    <= 1'b0;
        s1_pend_r.above_blk <= (row_r != '0);
        s1_pend_r.left_blk  <= last_row && (col_r != '0);
        s1_pend_r.self_blk  <= last_row && last_col;
      end
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end else if (q_push) begin
      s1_pend_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r  <= in_slot;
      s1_color_r <= in_color;
    end
    if (pix_fire) begin
      s1_px_r     <= in_pixel;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_x_gt0_r  <= (col_r != '0);
      s1_x_gt1_r  <= (col_r > col_t'(1));
      s1_x_last_r <= last_col;
      s1_r_gt0_r  <= (row_r != '0);
      s1_r_gt1_r  <= (row_r > row_t'(1));
      s1_cur1_r   <= hist1_r;
      s1_cur2_r   <= hist2_r;
      s1_diag_r   <= prev_x_r;
    end
  end

  // Neighbours of the chosen block; edges fall back to the centre
  always_comb begin
    nb_p    = s1_px_r;
    nb_a    = s1_r_gt0_r ? prev_x_r : s1_px_r;
    nb_b    = s1_px_r;
    nb_c    = s1_x_gt0_r ? s1_cur1_r : s1_px_r;
    nb_d    = s1_px_r;
    blk_col = s1_col_r;
    blk_row = s1_row_r;
    if (sel.above_blk) begin
      nb_p    = prev_x_r;
      nb_a    = s1_r_gt1_r ? old_x_r : prev_x_r;
      nb_b    = s1_x_last_r ? prev_x_r : prev_x1_r;
      nb_c    = s1_x_gt0_r ? s1_diag_r : prev_x_r;
      nb_d    = s1_px_r;
      blk_row = s1_row_r - 1'b1;
    end else if (sel.left_blk) begin
      nb_p    = s1_cur1_r;
      nb_a    = s1_r_gt0_r ? s1_diag_r : s1_cur1_r;
      nb_b    = s1_px_r;
      nb_c    = s1_x_gt1_r ? s1_cur2_r : s1_cur1_r;
      nb_d    = s1_cur1_r;
      blk_col = s1_col_r - 1'b1;
    end
    picked = scale2x(nb_p, nb_a, nb_b, nb_c, nb_d);
  end

  always_comb begin
    q_job        = '0;
    q_job.is_wr  = sel.pal_wr;
    q_job.slot   = s1_slot_r;
    q_job.color  = s1_color_r;
    q_job.col    = scx_pkg::COL_W'(blk_col);
    q_job.row    = blk_row;
    q_job.idx_tl = picked[scx_pkg::IDX_W-1:0];
    q_job.idx_tr = picked[2*scx_pkg::IDX_W-1:scx_pkg::IDX_W];
    q_job.idx_bl = picked[3*scx_pkg::IDX_W-1:2*scx_pkg::IDX_W];
    q_job.idx_br = picked[4*scx_pkg::IDX_W-1:3*scx_pkg::IDX_W];
    q_job.last   = !sel.pal_wr && !(rest.above_blk || rest.left_blk || rest.self_blk);
    q_job.done   = sel.self_blk;
  end

endmodule

`default_nettype wire

// ----- rtl/scx_job_queue.sv -----
`default_nettype none

module scx_job_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scx_pkg::scx_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output scx_pkg::scx_job_t head_job
);

  localparam int PW = $clog2(scx_pkg::QUEUE_DEPTH);

  scx_pkg::scx_job_t slots_r [scx_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;

  assign full       = (count_r == (PW+1)'(scx_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scx_back.sv -----
`default_nettype none

module scx_back #(
  parameter int PALETTE_ENTRIES = scx_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  scx_pkg::scx_job_t             q_job,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [scx_pkg::COL_W-1:0]     out_col,
  output logic [scx_pkg::ROW_W-1:0]     out_row,
  output logic [scx_pkg::COLOR_W-1:0]   out_tl,
  output logic [scx_pkg::COLOR_W-1:0]   out_tr,
  output logic [scx_pkg::COLOR_W-1:0]   out_bl,
  output logic [scx_pkg::COLOR_W-1:0]   out_br,
  output logic                          out_last,
  output logic                          out_done
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  typedef logic [scx_pkg::COLOR_W-1:0] color_t;

  logic   rd_en;
  logic   wr_en;
  logic   r_move;
  color_t rd_tl, rd_tr, rd_bl, rd_br;

  // Read stage
  logic                      r_valid_r;
  logic [scx_pkg::COL_W-1:0] r_col_r;
  logic [scx_pkg::ROW_W-1:0] r_row_r;
  logic                      r_last_r;
  logic                      r_done_r;
  logic [3:0]                r_zero_r;

  // Output register
  logic                      o_valid_r;
  logic [scx_pkg::COL_W-1:0] o_col_r;
  logic [scx_pkg::ROW_W-1:0] o_row_r;
  color_t                    o_tl_r, o_tr_r, o_bl_r, o_br_r;
  logic                      o_last_r;
  logic                      o_done_r;

  function automatic logic out_of_range(input logic [scx_pkg::IDX_W-1:0] idx);
    return (32'(idx) >= PALETTE_ENTRIES);
  endfunction

  assign r_move = r_valid_r && (!o_valid_r || out_ready);
  assign q_pop  = q_valid && (!r_valid_r || r_move);
  assign rd_en  = q_pop && !q_job.is_wr;
  assign wr_en  = q_pop && q_job.is_wr && !out_of_range(q_job.slot);

  // Two copies of the palette serve all four lookups of a block together
  scx_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_pal_top (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (q_job.slot[AW-1:0]),
    .wr_data   (q_job.color),
    .rd_en     (rd_en),
    .rd_addr_a (q_job.idx_tl[AW-1:0]),
    .rd_addr_b (q_job.idx_tr[AW-1:0]),
    .rd_data_a (rd_tl),
    .rd_data_b (rd_tr)
  );

  scx_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_pal_bot (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (q_job.slot[AW-1:0]),
    .wr_data   (q_job.color),
    .rd_en     (rd_en),
    .rd_addr_a (q_job.idx_bl[AW-1:0]),
    .rd_addr_b (q_job.idx_br[AW-1:0]),
    .rd_data_a (rd_bl),
    .rd_data_b (rd_br)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (rd_en) begin
        r_valid_r <= 1'b1;
      end else if (r_move) begin
        r_valid_r <= 1'b0;
      end
      if (r_move) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      r_col_r  <= q_job.col;
      r_row_r  <= q_job.row;
      r_last_r <= q_job.last;
      r_done_r <= q_job.done;
      r_zero_r <= {out_of_range(q_job.idx_br), out_of_range(q_job.idx_bl),
                   out_of_range(q_job.idx_tr), out_of_range(q_job.idx_tl)};
    end
    if (r_move) begin
      o_col_r  <= r_col_r;
      o_row_r  <= r_row_r;
      o_last_r <= r_last_r;
      o_done_r <= r_done_r;
      o_tl_r   <= r_zero_r[0] ? '0 : rd_tl;
      o_tr_r   <= r_zero_r[1] ? '0 : rd_tr;
      o_bl_r   <= r_zero_r[2] ? '0 : rd_bl;
      o_br_r   <= r_zero_r[3] ? '0 : rd_br;
    end
  end

  assign out_valid = o_valid_r;
  assign out_col   = o_col_r;
  assign out_row   = o_row_r;
  assign out_tl    = o_tl_r;
  assign out_tr    = o_tr_r;
  assign out_bl    = o_bl_r;
  assign out_br    = o_br_r;
  assign out_last  = o_last_r;
  assign out_done  = o_done_r;

endmodule

`default_nettype wire

// ----- rtl/scale2x_palette_upscaler.sv -----
// A block passes the classify stage, the request queue, the palette read stage and the output register.
// Throughput: one input item per cycle while the request queue has room; at most one block
// per cycle on the output, set by the output register and the two dual-read palette copies
// (four lookups per block). On the last row a pixel releases up to two blocks (three at frame
// end), so input slows there. Reset: counters and handshake state clear, frame size returns
// to 1024 x 768; palette and line buffers hold nothing defined until written.
`default_nettype none

module scale2x_palette_upscaler #(
  parameter int MAX_LINE_WIDTH  = scx_pkg::MAX_LINE_WIDTH_DEF,
  parameter int PALETTE_ENTRIES = scx_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [scx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scx_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pixel_index[7:0], palette_slot[15:8], palette_color[47:16]
  input  logic [scx_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // block_col[9:0], block_row[21:10], color_top_left[53:22], color_top_right[85:54],
  // color_bottom_left[117:86], color_bottom_right[149:118], zero[151:150]
  output logic [scx_pkg::OUT_DATA_W-1:0]     out_tdata,
  // last_of_run
  output logic                               out_tlast,
  // frame_done[0]
  output logic                               out_tuser
);

  scx_pkg::scx_job_t push_job;
  scx_pkg::scx_job_t head_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  logic [scx_pkg::COL_W-1:0]   blk_col;
  logic [scx_pkg::ROW_W-1:0]   blk_row;
  logic [scx_pkg::COLOR_W-1:0] c_tl, c_tr, c_bl, c_br;

  scx_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_pixel    (in_tdata[7:0]),
    .in_slot     (in_tdata[15:8]),
    .in_color    (in_tdata[47:16]),
    .q_push      (q_push),
    .q_job       (push_job),
    .q_full      (q_full)
  );

  scx_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  scx_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_col   (blk_col),
    .out_row   (blk_row),
    .out_tl    (c_tl),
    .out_tr    (c_tr),
    .out_bl    (c_bl),
    .out_br    (c_br),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  assign out_tdata = {2'b00, c_br, c_bl, c_tr, c_tl, blk_row, blk_col};

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("request popped from an empty queue");

  a_frame_end_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end block is not the last of its run");

  a_idle_after_reset : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

`default_nettype wire

// ----- verif/scale2x_block_checker.sv -----
`timescale 1ns / 100ps

module scale2x_block_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [scx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scx_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  // pixel_index[7:0], palette_slot[15:8], palette_color[47:16]
  input  logic [scx_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation[0]
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // block_col[9:0], block_row[21:10], color_top_left[53:22], color_top_right[85:54],
  // color_bottom_left[117:86], color_bottom_right[149:118], zero[151:150]
  input  logic [scx_pkg::OUT_DATA_W-1:0]     out_tdata,
  // last_of_run
  input  logic                               out_tlast,
  // frame_done[0]
  input  logic                               out_tuser,
  output int                                 mismatch_count,
  output int                                 pending_blocks
);
  import scx_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
    logic               run_end;
    logic               frame_end;
  } block_t;

  block_t             expected_blocks[$];
  logic [COLOR_W-1:0] palette_copy [PALETTE_ENTRIES_DEF];
  logic [IDX_W-1:0]   line_above [MAX_LINE_WIDTH_DEF];
  logic [IDX_W-1:0]   line_now [MAX_LINE_WIDTH_DEF];
  int                 col_cnt;
  int                 row_cnt;
  logic [FW_W-1:0]    frame_w;
  logic [FH_W-1:0]    frame_h;
  block_t             want;

  function automatic logic [COLOR_W-1:0] colour_of(input logic [IDX_W-1:0] idx);
    if (int'(idx) >= PALETTE_ENTRIES_DEF) return '0;
    return palette_copy[idx];
  endfunction

  // p centre, a above, b right, c left, d below
  function automatic block_t scale_block(input int col, input int row,
                                         input logic [IDX_W-1:0] p, a, b, c, d);
    block_t blk;
    blk.col          = COL_W'(col);
    blk.row          = ROW_W'(row);
    blk.top_left     = colour_of((c == a && c != d && a != b) ? a : p);
    blk.top_right    = colour_of((a == b && a != c && b != d) ? b : p);
    blk.bottom_left  = colour_of((d == c && d != b && c != a) ? c : p);
    blk.bottom_right = colour_of((b == d && b != a && d != c) ? d : p);
    blk.run_end      = 1'b0;
    blk.frame_end    = 1'b0;
    return blk;
  endfunction

  task automatic take_pixel(input logic [IDX_W-1:0] px);
    int               w;
    int               h;
    int               x;
    int               r;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    block_t           blk;
    block_t           run[$];
    w = (frame_w == 0) ? 1 : int'(frame_w);
    if (w > MAX_LINE_WIDTH_DEF) w = MAX_LINE_WIDTH_DEF;
    h = (frame_h == 0) ? 1 : int'(frame_h);
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    x = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;

    // the pixel above is complete now that its lower neighbour is here
    if (r > 0) begin
      p = line_now[x];
      a = (r > 1) ? line_above[x] : p;
      c = (x > 0) ? line_above[x-1] : p;
      b = (x + 1 < w) ? line_now[x+1] : p;
      run.push_back(scale_block(x, r - 1, p, a, b, c, px));
    end
    line_above[x] = line_now[x];
    line_now[x]   = px;

    // bottom row has no lower neighbour: release on the right neighbour
    if (r + 1 == h) begin
      if (x > 0) begin
        p = line_now[x-1];
        a = (r > 0) ? line_above[x-1] : p;
        c = (x > 1) ? line_now[x-2] : p;
        run.push_back(scale_block(x - 1, r, p, a, px, c, p));
      end
      if (x + 1 == w) begin
        a = (r > 0) ? line_above[x] : px;
        c = (x > 0) ? line_now[x-1] : px;
        blk = scale_block(x, r, px, a, px, c, px);
        blk.frame_end = 1'b1;
        run.push_back(blk);
      end
    end
    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) expected_blocks.push_back(run[i]);

    if (x + 1 < w) begin
      col_cnt = x + 1;
      row_cnt = r;
    end else if (r + 1 < h) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_blocks.delete();
      col_cnt = 0;
      row_cnt = 0;
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          mismatch_count++;
          $display("%0t: block expected none actual %h", $time, out_tdata);
        end else begin
          want = expected_blocks.pop_front();
          check_field("block_col", want.col, out_tdata[9:0]);
          check_field("block_row", want.row, out_tdata[21:10]);
          check_field("color_top_left", want.top_left, out_tdata[53:22]);
          check_field("color_top_right", want.top_right, out_tdata[85:54]);
          check_field("color_bottom_left", want.bottom_left, out_tdata[117:86]);
          check_field("color_bottom_right", want.bottom_right, out_tdata[149:118]);
          check_field("last_of_run", want.run_end, out_tlast);
          check_field("frame_done", want.frame_end, out_tuser);
        end
      end
      // a register write restarts the frame
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FRAME_WIDTH) begin
          frame_w = cfg_wr_data[FW_W-1:0];
        end else if (cfg_index == CFG_FRAME_HEIGHT) begin
          frame_h = cfg_wr_data[FH_W-1:0];
        end
        col_cnt = 0;
        row_cnt = 0;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_PALETTE) begin
          palette_copy[in_tdata[15:8]] = in_tdata[47:16];
        end else begin
          take_pixel(in_tdata[7:0]);
        end
      end
    end
    pending_blocks = expected_blocks.size();
  end

endmodule

// ----- verif/scale2x_palette_upscaler_tb.sv -----
`timescale 1ns / 100ps

module scale2x_palette_upscaler_tb;
  import scx_pkg::*;

  localparam int RANDOM_ITEMS = 170;
  localparam int WIDE_ROW     = 2047;
  localparam int TALL_FRAME   = 8191;
  localparam int TAIL_PIXELS  = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 10;

  // 4 x 3 frame laid out so both diagonal rules fire; first pixel listed first
  localparam logic [11:0][7:0] DIAG_FRAME = {
    8'h00, 8'h00, 8'hFF, 8'h55,
    8'h00, 8'hFF, 8'h55, 8'h55,
    8'hFF, 8'h55, 8'h55, 8'h00
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  int                    mismatch_count;
  int                    pending_blocks;

  bit                    no_idle;
  bit                    hold_off_req;
  bit [255:0]            slot_written;
  logic [IDX_W-1:0]      written_slots[$];
  logic [IDX_W-1:0]      tone [3];
  int                    sent_items;

  always #5 clk = ~clk;

  scale2x_palette_upscaler DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  scale2x_block_checker block_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending_blocks (pending_blocks)
  );

  // Entered and left on a falling edge
  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [IDX_W-1:0] slot, input logic [COLOR_W-1:0] color);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {color, slot, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_palette(input logic [IDX_W-1:0] slot, input logic [COLOR_W-1:0] color);
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      written_slots.push_back(slot);
    end
    send_request(OP_PALETTE, IDX_W'($urandom), slot, color);
  endtask

  task automatic send_pixel(input logic [IDX_W-1:0] idx);
    send_request(OP_PIXEL, idx, IDX_W'($urandom), $urandom);
  endtask

  // Mostly a few shades so neighbours match; now and then any loaded entry
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 8) return tone[$urandom_range(0, 2)];
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  task automatic send_frame(input int pixels);
    for (int k = 0; k < 3; k++) begin
      tone[k] = written_slots[$urandom_range(0, written_slots.size() - 1)];
    end
    for (int n = 0; n < pixels; n++) begin
      if ($urandom_range(0, 9) == 0) write_palette(IDX_W'($urandom), $urandom);
      send_pixel(pick_index());
    end
  endtask

  // Hold the input until every block is out, then let the pipeline settle
  task automatic drain_blocks();
    in_tvalid <= 1'b0;
    while (pending_blocks != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    drain_blocks();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // Receiver: random stalls per block, plus one long hold-off on request
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  initial begin
    int w;
    int h;
    int phase;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    write_palette(8'h00, 32'h0000_0000);
    write_palette(8'hFF, 32'hFFFF_FFFF);
    write_palette(8'h55, 32'h1234_5678);
    write_palette(8'hAA, 32'hEDCB_A987);
    write_palette(8'h0F, $urandom);
    write_palette(8'hF0, $urandom);
    write_palette(8'h3C, $urandom);
    write_palette(8'hC3, $urandom);

    set_frame(4, 3);
    for (int i = 11; i >= 0; i--) send_pixel(DIAG_FRAME[i]);

    // zero sizes act as a single pixel frame
    set_frame(0, 0);
    send_pixel(8'hAA);
    send_pixel(8'hFF);
    send_pixel(8'h0F);

    sent_items = 0;
    phase = 0;
    // always reach the hold-off phase and the back-to-back phase
    while (sent_items < RANDOM_ITEMS || phase < 4) begin
      no_idle = (phase % 4 == 3);
      if (phase == 2) begin
        w = 4;
        h = 4;
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 5);
      end
      set_frame(w, h);
      if (phase == 2) begin
        // keep requests coming while the receiver holds off
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        repeat (3) send_frame(w * h);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_frame(w * h);
          if ($urandom_range(0, 3) == 0) drain_blocks();
        end
      end
      // abandon a frame part way; the next register write restarts it
      if ($urandom_range(0, 2) == 0) send_frame($urandom_range(1, w * h));
      phase++;
    end

    // oversized registers clamp; a short stretch of each frame is enough
    no_idle = 1'b0;
    set_frame(WIDE_ROW, 1);
    send_frame(TAIL_PIXELS);

    no_idle = 1'b1;
    set_frame(1, TALL_FRAME);
    send_frame(TAIL_PIXELS);

    drain_blocks();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
